FILE: hw/rtl/u8pci_pkg.sv
// Shared types, constants and helpers of the UTF-8 pause comma inserter.
package u8pci_pkg;

   // Default threshold and queue depth
   localparam logic [7:0] PAUSE_THRESHOLD_RESET = 8'd12;
   localparam int         QUEUE_DEPTH_DEFAULT   = 4;

   // Byte values used by the classifier and the comma sequencer
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD2_MIN   = 8'hC0;
   localparam logic [7:0] SPACE_CHAR  = 8'h20;
   localparam logic [7:0] ASCII_COMMA = 8'h2C;
   localparam logic [7:0] ASCII_DOT   = 8'h2E;
   localparam logic [7:0] ASCII_BANG  = 8'h21;
   localparam logic [7:0] ASCII_QUEST = 8'h3F;
   localparam logic [7:0] CJK_LEAD_A  = 8'hE3;
   localparam logic [7:0] CJK_MID_A   = 8'h80;
   localparam logic [7:0] CJK_LEAD_B  = 8'hEF;
   localparam logic [7:0] CJK_MID_B   = 8'hBC;
   localparam logic [7:0] MARK_STOP   = 8'h82;
   localparam logic [7:0] MARK_PAUSE  = 8'h81;
   localparam logic [7:0] MARK_QUEST  = 8'h9F;
   localparam logic [7:0] MARK_COMMA  = 8'h8C;
   localparam logic [7:0] MARK_SEMI   = 8'h9B;
   localparam logic [7:0] COUNT_MAX   = 8'hFF;

   // Full-width comma, emitted as three beats ahead of the lead byte
   localparam logic [7:0] FW_COMMA_0 = 8'hEF;
   localparam logic [7:0] FW_COMMA_1 = 8'hBC;
   localparam logic [7:0] FW_COMMA_2 = 8'h8C;

   // Input beat
   typedef struct packed {
      logic [7:0] in_byte;
      logic       text_end;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_end_out;
   } rsp_type;

   // Classified byte passed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       text_end;
      logic       comma;
   } entry_type;

   // Three-byte CJK punctuation that clears the counter
   function automatic logic is_mark(input logic [7:0] a, input logic [7:0] s,
                                    input logic [7:0] c);
      logic r;
      r = 1'b0;
      if (a == CJK_LEAD_A && s == CJK_MID_A) begin
         r = (c == MARK_STOP) || (c == MARK_PAUSE);
      end else if (a == CJK_LEAD_B && s == CJK_MID_B) begin
         r = (c == MARK_PAUSE) || (c == MARK_QUEST) || (c == MARK_COMMA) ||
             (c == MARK_SEMI);
      end
      return r;
   endfunction

   // Saturating increment of the pause counter
   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == COUNT_MAX) ? v : v + 8'd1;
   endfunction

endpackage

FILE: hw/rtl/utf8_pause_comma_inserter.sv
// Top level of the UTF-8 pause comma inserter.
//
// Usage: UTF-8 text enters one byte per beat on the req_ channel (req_valid,
// req_stall, req_data with in_byte and text_end). Every byte leaves on the
// rsp_ channel; ahead of a lead byte that ends a long run of wide characters
// the three bytes of a full-width comma EF BC 8C are sent first. run_last
// marks the final beat caused by one input byte, text_end_out the final beat
// of a text. The pause threshold is written through csr_valid/csr_data
// (csr_ready is always high); reset sets it to 12. The user must write it
// only while the block is idle; the block itself does not enforce this.
// An accepted byte passes through the queue and the output register to rsp.
// Throughput: one byte per cycle while req_stall is low; a byte that gets a
// comma leaves as four beats via the single output register. A queue of
// QUEUE_DEPTH entries between classifier and output sequencer absorbs those
// bursts; req_stall rises only when it is full.
// Reset clears all character state and the queue, and drops any pending
// result. When the receiver stalls, the output beat holds, the queue fills
// and then the input is stalled.
module utf8_pause_comma_inserter import u8pci_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   entry_type entry;
   entry_type head_data;
   logic      full;
   logic      head_valid;
   logic      pop;
   logic      accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign csr_ready = 1'b1;

   u8pci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .accept    (accept),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .entry     (entry)
   );

   u8pci_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (entry),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   u8pci_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: hw/rtl/u8pci_front.sv
// Front end: accepts bytes, tracks characters and decides on comma insertion.
module u8pci_front import u8pci_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  req_type   req_data,
   input  logic      accept,
   input  logic      csr_valid,
   input  logic [7:0] csr_data,
   output entry_type entry
);

   logic [7:0]  thr_ff, thr_in;
   logic [7:0]  count_ff, count_in;
   logic [2:0]  left_ff, left_in;
   logic [2:0]  len_ff, len_in;
   logic [15:0] head_ff, head_in;
   logic        seen_ff, seen_in;

   logic [7:0] b;
   logic       new_char;
   logic       comma;
   logic [7:0] base_count;
   logic [2:0] pos;

   assign b        = req_data.in_byte;
   assign new_char = (left_ff == 3'd0);
   assign comma    = req_valid && new_char && seen_ff && (count_ff >= thr_ff) &&
                     (b[7] || b == SPACE_CHAR);
   assign base_count = comma ? 8'd0 : count_ff;
   assign pos        = len_ff - left_ff;

   // Classified entry for the queue
   assign entry = '{data: b, text_end: req_data.text_end, comma: comma};

   // Threshold register
   always_comb begin
      thr_in = csr_valid ? csr_data : thr_ff;
   end

   // Character tracking and pause counting
   always_comb begin
      count_in = count_ff;
      left_in  = left_ff;
      len_in   = len_ff;
      head_in  = head_ff;
      seen_in  = seen_ff;
      if (accept) begin
         if (new_char) begin
            seen_in  = 1'b1;
            head_in  = {b, 8'h00};
            count_in = base_count;
            if (b >= LEAD4_MIN) begin
               len_in   = 3'd4;
               left_in  = 3'd3;
               count_in = sat_inc(base_count);
            end else if (b >= LEAD3_MIN) begin
               len_in  = 3'd3;
               left_in = 3'd2;
            end else if (b >= LEAD2_MIN) begin
               len_in  = 3'd2;
               left_in = 3'd1;
            end else begin
               len_in  = 3'd1;
               left_in = 3'd0;
               if (b == ASCII_COMMA || b == ASCII_DOT || b == ASCII_BANG ||
                   b == ASCII_QUEST) begin
                  count_in = 8'd0;
               end
            end
         end else begin
            if (pos == 3'd1) begin
               head_in = {head_ff[15:8], b};
            end
            if (pos == 3'd2 && len_ff == 3'd3) begin
               count_in = is_mark(head_ff[15:8], head_ff[7:0], b) ? 8'd0
                                                                  : sat_inc(count_ff);
            end
            left_in = left_ff - 3'd1;
         end
         // End of text: return to reset state
         if (req_data.text_end) begin
            count_in = 8'd0;
            left_in  = 3'd0;
            len_in   = 3'd0;
            head_in  = 16'h0000;
            seen_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= PAUSE_THRESHOLD_RESET;
         count_ff <= 8'd0;
         left_ff  <= 3'd0;
         len_ff   <= 3'd0;
         head_ff  <= 16'h0000;
         seen_ff  <= 1'b0;
      end else begin
         thr_ff   <= thr_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         len_ff   <= len_in;
         head_ff  <= head_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

FILE: hw/rtl/u8pci_queue.sv
// Small register queue between the front end and the back end.
module u8pci_queue import u8pci_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output entry_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/u8pci_back.sv
// Back end: expands queued bytes into result beats through an output register.
module u8pci_back import u8pci_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head_data,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   logic [1:0] phase_ff, phase_in;
   logic       valid_ff, valid_in;
   rsp_type    data_ff, data_in;
   logic       load;
   logic       last;
   logic [7:0] beat_byte;

   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign last = !head_data.comma || (phase_ff == 2'd3);
   assign pop  = load && last;

   // Select the byte of this beat
   always_comb begin
      beat_byte = head_data.data;
      if (head_data.comma) begin
         unique case (phase_ff)
            2'd0:    beat_byte = FW_COMMA_0;
            2'd1:    beat_byte = FW_COMMA_1;
            2'd2:    beat_byte = FW_COMMA_2;
            default: beat_byte = head_data.data;
         endcase
      end
   end

   // Advance the beat sequence and fill the output register
   always_comb begin
      phase_in = phase_ff;
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (load) begin
         phase_in = last ? 2'd0 : phase_ff + 2'd1;
         valid_in = 1'b1;
         data_in  = '{out_byte: beat_byte, run_last: last,
                      text_end_out: last && head_data.text_end};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // Mid-sequence implies a comma entry waiting at the head
   a_phase_comma: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != 2'd0) |-> (head_valid && head_data.comma))
      else $error("comma sequence without comma entry");

   // End flag only on the last beat of a byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff.text_end_out) |-> data_ff.run_last)
      else $error("text end on a non-final beat");

   // A non-final beat advances the sequence by one
   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      (load && !last) |=> (phase_ff == $past(phase_ff) + 2'd1))
      else $error("comma sequence did not advance");

endmodule

FILE: tb/utf8_pause_comma_inserter_test.sv
// Self-checking testbench for the UTF-8 pause comma inserter.
`timescale 1ns / 100ps

module utf8_pause_comma_inserter_test;
   import u8pci_pkg::*;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int PHASE_BYTES  = 26;
   localparam int SETTLE_WAIT  = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = '0;

   // Bytes waiting to be sent and beats waiting to be seen
   req_type text_queue[$];
   rsp_type expected_beats[$];
   int      bytes_queued = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      error_count = 0;
   int      cycle_count = 0;

   // Predictor state
   logic [7:0]  pause_limit = PAUSE_THRESHOLD_RESET;
   logic [7:0]  pause_count = '0;
   logic [2:0]  cont_left = '0;
   logic [2:0]  open_size = '0;
   logic [15:0] lead_pair = '0;
   bit          char_open = 1'b0;

   utf8_pause_comma_inserter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Full-width and ideographic punctuation that ends a pause run
   function automatic bit is_pause_mark(input logic [7:0] a, input logic [7:0] s,
                                        input logic [7:0] c);
      if (a == CJK_LEAD_A && s == CJK_MID_A) begin
         return c == MARK_STOP || c == MARK_PAUSE;
      end
      if (a == CJK_LEAD_B && s == CJK_MID_B) begin
         return c == MARK_PAUSE || c == MARK_QUEST || c == MARK_COMMA ||
                c == MARK_SEMI;
      end
      return 1'b0;
   endfunction

   // Work out the beats one accepted byte causes and queue them
   task automatic predict_byte(input req_type beat);
      rsp_type    out;
      logic [7:0] b;
      logic [2:0] pos;
      b = beat.in_byte;
      out = '0;
      if (cont_left == 0) begin
         // new character: maybe insert a comma ahead of its lead byte
         if (char_open && pause_count >= pause_limit &&
             (b >= 8'h80 || b == SPACE_CHAR)) begin
            out.out_byte = FW_COMMA_0;
            expected_beats = {expected_beats, out};
            out.out_byte = FW_COMMA_1;
            expected_beats = {expected_beats, out};
            out.out_byte = FW_COMMA_2;
            expected_beats = {expected_beats, out};
            pause_count = '0;
         end
         char_open = 1'b1;
         lead_pair = {b, 8'h00};
         if (b >= LEAD4_MIN) begin
            open_size = 3'd4;
            cont_left = 3'd3;
            if (pause_count != COUNT_MAX) pause_count++;
         end else if (b >= LEAD3_MIN) begin
            open_size = 3'd3;
            cont_left = 3'd2;
         end else if (b >= LEAD2_MIN) begin
            open_size = 3'd2;
            cont_left = 3'd1;
         end else begin
            open_size = 3'd1;
            cont_left = 3'd0;
            if (b == ASCII_COMMA || b == ASCII_DOT || b == ASCII_BANG || b == ASCII_QUEST)
               pause_count = '0;
         end
      end else begin
         // continuation: three-byte characters count on their last byte
         pos = open_size - cont_left;
         if (pos == 3'd1) lead_pair[7:0] = b;
         if (pos == 3'd2 && open_size == 3'd3) begin
            if (is_pause_mark(lead_pair[15:8], lead_pair[7:0], b)) begin
               pause_count = '0;
            end else if (pause_count != COUNT_MAX) begin
               pause_count++;
            end
         end
         cont_left--;
      end
      out.out_byte = b;
      out.run_last = 1'b1;
      out.text_end_out = beat.text_end;
      expected_beats = {expected_beats, out};
      if (beat.text_end) begin
         pause_count = '0;
         cont_left = '0;
         open_size = '0;
         lead_pair = '0;
         char_open = 1'b0;
      end
   endtask

   // Driver: hold a stalled beat, otherwise offer the next byte or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_byte(req_data);
         if (!req_valid || !req_stall) begin
            if (text_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= text_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted beat with the oldest expected one
   always @(posedge clock) begin : check_beats
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %h actual %h", $time,
                           want.out_byte, rsp_data.out_byte);
                  error_count++;
               end
               if (rsp_data.run_last !== want.run_last) begin
                  $display("%0t: run_last expected %b actual %b", $time,
                           want.run_last, rsp_data.run_last);
                  error_count++;
               end
               if (rsp_data.text_end_out !== want.text_end_out) begin
                  $display("%0t: text_end_out expected %b actual %b", $time,
                           want.text_end_out, rsp_data.text_end_out);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic add_byte(input logic [7:0] value, input logic last);
      req_type beat;
      beat.in_byte = value;
      beat.text_end = last;
      text_queue = {text_queue, beat};
      bytes_queued++;
   endtask

   // Continuation byte: mostly well formed, sometimes any value
   function automatic logic [7:0] tail_byte();
      if ($urandom_range(4) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(8'hBF, 8'h80));
   endfunction

   // Build one text of random characters, sometimes cut short, and queue it
   task automatic make_text(input int n_chars);
      logic [7:0] seq[$];
      int         kind;
      int         k;
      for (k = 0; k < n_chars; k++) begin
         kind = $urandom_range(99);
         if (kind < 40) begin
            seq = {seq, 8'($urandom_range(8'hEF, 8'hE0))};
            seq = {seq, tail_byte()};
            seq = {seq, tail_byte()};
         end else if (kind < 52) begin
            seq = {seq, 8'($urandom_range(8'hFF, 8'hF0))};
            seq = {seq, tail_byte()};
            seq = {seq, tail_byte()};
            seq = {seq, tail_byte()};
         end else if (kind < 64) begin
            case ($urandom_range(5))
               0: seq = {seq, CJK_LEAD_A, CJK_MID_A, MARK_STOP};
               1: seq = {seq, CJK_LEAD_A, CJK_MID_A, MARK_PAUSE};
               2: seq = {seq, CJK_LEAD_B, CJK_MID_B, MARK_PAUSE};
               3: seq = {seq, CJK_LEAD_B, CJK_MID_B, MARK_QUEST};
               4: seq = {seq, CJK_LEAD_B, CJK_MID_B, MARK_COMMA};
               default: seq = {seq, CJK_LEAD_B, CJK_MID_B, MARK_SEMI};
            endcase
         end else if (kind < 74) begin
            seq = {seq, 8'($urandom_range(8'h7F))};
         end else if (kind < 80) begin
            seq = {seq, SPACE_CHAR};
         end else if (kind < 86) begin
            case ($urandom_range(3))
               0: seq = {seq, ASCII_COMMA};
               1: seq = {seq, ASCII_DOT};
               2: seq = {seq, ASCII_BANG};
               default: seq = {seq, ASCII_QUEST};
            endcase
         end else if (kind < 92) begin
            seq = {seq, 8'($urandom_range(8'hDF, 8'hC0))};
            seq = {seq, tail_byte()};
         end else begin
            seq = {seq, 8'($urandom_range(255))};
         end
      end
      // drop the last byte now and then to end on a broken character
      if (seq.size() > 1 && $urandom_range(9) == 0) void'(seq.pop_back());
      for (k = 0; k < seq.size(); k++) add_byte(seq[k], k == seq.size() - 1);
   endtask

   task automatic write_threshold(input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pause_limit = value;
   endtask

   // Return once every byte is sent and every expected beat has arrived
   task automatic wait_drained();
      do @(negedge clock);
      while (text_queue.size() != 0 || req_valid || expected_beats.size() != 0);
   endtask

   task automatic run_phase(input logic [7:0] threshold, input int idle_pct,
                            input int hold_pct);
      int start;
      write_threshold(threshold);
      send_idle_pct = idle_pct;
      stall_pct = hold_pct;
      start = bytes_queued;
      while (bytes_queued - start < PHASE_BYTES) make_text($urandom_range(14, 1));
      wait_drained();
   endtask

   initial begin
      logic [7:0] first_text[];
      logic [7:0] second_text[];
      int k;
      first_text = '{8'h00, 8'hF0, 8'h9F, 8'h98, 8'h80,
                     8'hE4, 8'hB8, 8'hAD, 8'h20};
      second_text = '{8'hE4, 8'hB8, 8'hAD, 8'hE4, 8'hB8, 8'hAD,
                      8'h80, 8'hEF, 8'hBC, 8'h9F, 8'hC3, 8'hA9,
                      8'h21, 8'hFF, 8'h80};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: comma before a space and before a stray continuation byte,
      // a mark, a two-byte character, punctuation, a cut-off four-byte end
      write_threshold(8'd2);
      for (k = 0; k < first_text.size(); k++)
         add_byte(first_text[k], k == first_text.size() - 1);
      for (k = 0; k < second_text.size(); k++)
         add_byte(second_text[k], k == second_text.size() - 1);
      wait_drained();

      // Random texts under several thresholds and idle patterns
      run_phase(8'd1, 0, 0);
      run_phase(8'd255, 52, 0);
      run_phase(8'd3, 0, 52);
      run_phase(8'd12, 23, 23);

      repeat (SETTLE_WAIT) @(posedge clock);
      if (expected_beats.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
